// ----- rtl/paos_pkg.sv -----
package paos_pkg;

    // Widths of the fixed word fields.
    localparam int unsigned QID_W   = 8;
    localparam int unsigned COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Event codes carried on the opcode field.
    typedef enum logic [1:0] {
        OP_ARRIVE  = 2'd0,
        OP_DROP    = 2'd1,
        OP_REQUEST = 2'd2
    } op_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_META,
        ST_POP
    } state_t;

endpackage

// ----- rtl/port_arrival_order_scheduler_core.sv -----
// Channel   Handshake          Fields
// -------   ----------------   ---------------------------------------------------
// command   start / busy       opcode, port, direction, queue_id, is_management,
//                              management_waiting
// result    done (one cycle)   granted, from_management, served_queue,
//                              message_total, list_full
//
// A word is taken when start is high and busy is low. The per-slot record, and
// then for a request that pops the order list the list entry, each come out of a
// memory with a registered read port before the result is set with done. The next
// word can be taken in the cycle that done is high. Reset clears the per-slot
// valid bits, so every record reads as zero at once; no clearing pass is needed.
// The receiver cannot stall the result.
module port_arrival_order_scheduler_core #(
    parameter int unsigned PORTS      = 4,
    parameter int unsigned LIST_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [1:0]                    port,
    input  logic                          direction,
    input  logic [paos_pkg::QID_W-1:0]    queue_id,
    input  logic                          is_management,
    input  logic                          management_waiting,
    output logic                          done,
    output logic                          granted,
    output logic                          from_management,
    output logic [paos_pkg::QID_W-1:0]    served_queue,
    output logic [paos_pkg::COUNT_W-1:0]  message_total,
    output logic                          list_full
);

    import paos_pkg::*;

    localparam int unsigned SLOTS = 2 * PORTS;
    localparam int unsigned SW    = $clog2(SLOTS);
    localparam int unsigned HW    = $clog2(LIST_DEPTH);
    localparam int unsigned FW    = $clog2(LIST_DEPTH + 1);
    localparam int unsigned MW    = HW + FW + COUNT_W;
    localparam int unsigned ODEP  = SLOTS * LIST_DEPTH;
    localparam int unsigned OAW   = $clog2(ODEP);

    state_t state_reg, state_next;

    // Latched command word.
    logic [1:0]       op_reg;
    logic [SW-1:0]    slot_reg;
    logic             port_ok_reg;
    logic [QID_W-1:0] qid_reg;
    logic             mgmt_reg;
    logic             wait_reg;

    // Per-slot record valid bits.
    logic [(1 << SW)-1:0] valid_reg;

    // Result registers.
    logic               done_reg, done_next;
    logic               granted_reg;
    logic               from_mgmt_reg;
    logic [QID_W-1:0]   served_reg;
    logic [COUNT_W-1:0] total_reg;
    logic               full_reg;

    // Memory ports.
    logic [SW-1:0]    meta_raddr;
    logic [MW-1:0]    meta_rdata;
    logic             meta_we;
    logic [MW-1:0]    meta_wdata;
    logic [OAW-1:0]   ord_raddr;
    logic [QID_W-1:0] ord_rdata;
    logic             ord_we;
    logic [OAW-1:0]   ord_waddr;

    logic             accept;
    logic [SW-1:0]    in_slot;
    logic             in_port_ok;
    logic [6:0]       slot_wide;

    // Record fields and their updates.
    logic [MW-1:0]      meta_cur;
    logic [HW-1:0]      head_cur, head_new;
    logic [FW-1:0]      fill_cur, fill_new;
    logic [COUNT_W-1:0] count_cur, count_new;
    logic [COUNT_W-1:0] count_inc, count_dec;
    logic [HW:0]        pos_sum;
    logic [HW-1:0]      tail_pos;
    logic [HW-1:0]      head_inc;
    logic [OAW-1:0]     slot_base;
    logic               pop;
    logic               res_granted, res_mgmt, res_full;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign slot_wide  = {4'd0, port, direction};
    assign in_slot    = slot_wide[SW-1:0];
    assign in_port_ok = ({5'd0, port} < 7'(PORTS));
    assign meta_raddr = in_slot;

    paos_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (slot_reg),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    paos_ram #(.WIDTH(QID_W), .DEPTH(ODEP)) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (qid_reg),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    // Unpack the slot record; a slot never written reads as zero.
    assign meta_cur  = valid_reg[slot_reg] ? meta_rdata : '0;
    assign head_cur  = meta_cur[MW-1 -: HW];
    assign fill_cur  = meta_cur[COUNT_W +: FW];
    assign count_cur = meta_cur[COUNT_W-1:0];

    assign count_inc = (count_cur != COUNT_MAX) ? count_cur + 1'b1 : count_cur;
    assign count_dec = (count_cur != '0) ? count_cur - 1'b1 : count_cur;

    // Tail position: head plus fill, wrapped once at the list depth.
    assign pos_sum  = {1'b0, head_cur} + (HW + 1)'(fill_cur);
    assign tail_pos = (pos_sum >= (HW + 1)'(LIST_DEPTH))
                      ? HW'(pos_sum - (HW + 1)'(LIST_DEPTH)) : pos_sum[HW-1:0];
    assign head_inc = (head_cur == HW'(LIST_DEPTH - 1)) ? '0 : head_cur + 1'b1;

    assign slot_base = OAW'(slot_reg) * OAW'(LIST_DEPTH);

    // Event update, evaluated while the slot record is on the read port.
    always_comb
    begin
        head_new    = head_cur;
        fill_new    = fill_cur;
        count_new   = count_cur;
        res_granted = 1'b0;
        res_mgmt    = 1'b0;
        res_full    = 1'b0;
        pop         = 1'b0;
        meta_we     = 1'b0;
        ord_we      = 1'b0;
        ord_waddr   = slot_base + OAW'(tail_pos);
        ord_raddr   = slot_base + OAW'(head_cur);
        if (state_reg == ST_META && port_ok_reg)
        begin
            case (op_reg)
                OP_ARRIVE:
                begin
                    meta_we   = 1'b1;
                    count_new = count_inc;
                    if (!mgmt_reg)
                    begin
                        if (fill_cur >= FW'(LIST_DEPTH))
                        begin
                            res_full = 1'b1;
                        end
                        else
                        begin
                            ord_we   = 1'b1;
                            fill_new = fill_cur + 1'b1;
                        end
                    end
                end
                OP_DROP:
                begin
                    meta_we   = 1'b1;
                    count_new = count_dec;
                    if (!mgmt_reg && fill_cur != '0)
                    begin
                        fill_new = fill_cur - 1'b1;
                    end
                end
                OP_REQUEST:
                begin
                    meta_we = 1'b1;
                    if (wait_reg)
                    begin
                        res_granted = 1'b1;
                        res_mgmt    = 1'b1;
                        count_new   = count_dec;
                    end
                    else if (fill_cur != '0)
                    begin
                        res_granted = 1'b1;
                        pop         = 1'b1;
                        head_new    = head_inc;
                        fill_new    = fill_cur - 1'b1;
                        count_new   = count_dec;
                    end
                end
                default:
                begin
                    meta_we = 1'b0;
                end
            endcase
        end
    end

    assign meta_wdata = {head_new, fill_new, count_new};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_META;
                end
            end
            ST_META:
            begin
                state_next = pop ? ST_POP : ST_IDLE;
            end
            ST_POP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result strobe.
    always_comb
    begin
        case (state_reg)
            ST_META: done_next = !pop;
            ST_POP:  done_next = 1'b1;
            default: done_next = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (meta_we)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    // Command latch and result registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            slot_reg    <= in_slot;
            port_ok_reg <= in_port_ok;
            qid_reg     <= queue_id;
            mgmt_reg    <= is_management;
            wait_reg    <= management_waiting;
        end
        if (state_reg == ST_META)
        begin
            granted_reg   <= res_granted;
            from_mgmt_reg <= res_mgmt;
            served_reg    <= '0;
            total_reg     <= port_ok_reg ? count_new : '0;
            full_reg      <= res_full;
        end
        else if (state_reg == ST_POP)
        begin
            served_reg <= ord_rdata;
        end
    end

    assign done            = done_reg;
    assign granted         = granted_reg;
    assign from_management = from_mgmt_reg;
    assign served_queue    = served_reg;
    assign message_total   = total_reg;
    assign list_full       = full_reg;

endmodule

// ----- rtl/paos_ram.sv -----
module paos_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
